/* rtl/core/bspd_pkg.sv */
// ---------------------------------------------------------------------------
// bspd_pkg
// Shared types and constants for the byte-stuffed packet deframer:
// register indexes, reset values of the code registers, and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package bspd_pkg;

    // default packet store depth
    localparam int DEFAULT_MAX_PACKET_BYTES = 64;

    // widths fixed by the interface
    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 7;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNSTUFF_MASK = 2'd3;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] RST_START_CODE   = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END_CODE     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE  = 8'd16;
    localparam logic [BYTE_W-1:0] RST_UNSTUFF_MASK = 8'd32;

    // controller to datapath commands
    typedef struct packed {
        logic intake;     // input transaction accepted this cycle
        logic rd_clear;   // restart replay at the first stored byte
        logic rd_en;      // fetch the byte at the replay pointer
        logic rd_step;    // advance the replay pointer
    } bspd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic deliver;    // current input byte closes a non-empty open packet
        logic last;       // replay pointer sits on the final stored byte
    } bspd_sts_t;

endpackage

/* rtl/core/bspd_datapath.sv */
// ---------------------------------------------------------------------------
// bspd_datapath
// Code registers, byte classification, unstuffing, packet store with
// fill count, and the replay pointer with registered store read.
// ---------------------------------------------------------------------------
module bspd_datapath
    import bspd_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // input payload
    input  logic [BYTE_W-1:0]    in_byte,
    // result payload
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 out_last,
    output logic [LENGTH_W-1:0]  out_length,
    // control
    input  bspd_cmd_t            cmd,
    output bspd_sts_t            sts
);

    localparam int AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] end_code_reg;
    logic [BYTE_W-1:0] escape_code_reg;
    logic [BYTE_W-1:0] unstuff_mask_reg;

    logic              open_reg, open_next;
    logic              pending_reg, pending_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [BYTE_W-1:0] rd_data_reg;

    logic [BYTE_W-1:0] store_mem [MAX_PACKET_BYTES];

    logic              is_start;
    logic              is_end;
    logic              is_escape;
    logic              full;
    logic              store_we;
    logic [BYTE_W-1:0] data_byte;
    logic [CW-1:0]     rd_count;
    logic [CW+LENGTH_W-1:0] fill_ext;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg   <= RST_START_CODE;
            end_code_reg     <= RST_END_CODE;
            escape_code_reg  <= RST_ESCAPE_CODE;
            unstuff_mask_reg <= RST_UNSTUFF_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_CODE:   start_code_reg   <= cfg_data;
                REG_END_CODE:     end_code_reg     <= cfg_data;
                REG_ESCAPE_CODE:  escape_code_reg  <= cfg_data;
                REG_UNSTUFF_MASK: unstuff_mask_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // byte classification, start code wins over end, end over escape
    assign is_start  = (in_byte == start_code_reg);
    assign is_end    = !is_start && (in_byte == end_code_reg);
    assign is_escape = !is_start && !is_end && (in_byte == escape_code_reg);
    assign full      = (fill_reg == CW'(MAX_PACKET_BYTES));
    assign data_byte = pending_reg ? (in_byte & ~unstuff_mask_reg) : in_byte;

    assign sts.deliver = is_end && open_reg && (fill_reg != '0);

    // intake state update
    always_comb
    begin
        open_next    = open_reg;
        pending_next = pending_reg;
        fill_next    = fill_reg;
        store_we     = 1'b0;
        if (cmd.intake)
        begin
            if (is_start)
            begin
                fill_next = '0;
                open_next = 1'b1;
            end
            else if (is_end)
            begin
                open_next = 1'b0;
            end
            else if (is_escape)
            begin
                pending_next = 1'b1;
            end
            else if (open_reg)
            begin
                pending_next = 1'b0;
                if (!full)
                begin
                    store_we  = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
                else
                begin
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            pending_reg <= 1'b0;
            fill_reg    <= '0;
        end
        else
        begin
            open_reg    <= open_next;
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
        end
    end

    // packet store write
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[fill_reg[AW-1:0]] <= data_byte;
        end
    end

    // replay pointer
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clear)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_step)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    // registered store read, held while the result is stalled
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    // result fields
    assign rd_count   = CW'(rd_idx_reg) + CW'(1);
    assign sts.last   = (rd_count == fill_reg);
    assign fill_ext   = {{LENGTH_W{1'b0}}, fill_reg};
    assign out_byte   = rd_data_reg;
    assign out_last   = sts.last;
    assign out_length = fill_ext[LENGTH_W-1:0];

endmodule

/* rtl/core/bspd_ctrl.sv */
// ---------------------------------------------------------------------------
// bspd_ctrl
// Controller: takes input bytes while idle, and on a delivering end code
// walks the packet store, one fetch and one result transaction per byte.
// ---------------------------------------------------------------------------
module bspd_ctrl
    import bspd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output bspd_cmd_t cmd,
    input  bspd_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   in_take;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_SHOW);
    assign in_take   = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.intake   = 1'b0;
        cmd.rd_clear = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_step  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.intake = in_take;
                if (in_take && sts.deliver)
                begin
                    cmd.rd_clear = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!out_stall)
                begin
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_step = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/byte_stuffed_packet_deframer.sv */
// ---------------------------------------------------------------------------
// byte_stuffed_packet_deframer
// Removes start/end/escape byte stuffing from a serial byte stream and
// delivers each completed packet byte by byte with a last marker.
//
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_stall   in_byte
//   out       source     out_valid/out_stall out_byte, out_last, out_length
//   cfg       sink       cfg_we              cfg_index, cfg_data
//
// A byte that does not close a packet is taken without stalling, and the
// input stays ready for the next byte. A delivering end code replays the
// store, each result being a registered store read followed by the result
// transaction, so the input is held for the whole replay, stalls included.
// Reset puts the code registers at their defaults and closes any packet.
// A stalled result holds its fields; the input stays stalled until the
// last byte of the packet has been taken.
// ---------------------------------------------------------------------------
module byte_stuffed_packet_deframer
    import bspd_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    in_byte,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 out_last,
    output logic [LENGTH_W-1:0]  out_length
);

    bspd_cmd_t cmd;
    bspd_sts_t sts;

    // sequencing
    bspd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // registers, store and result fields
    bspd_datapath #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_byte    (in_byte),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .out_length (out_length),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

/* test/byte_stuffed_packet_deframer_tb.sv */
// ---------------------------------------------------------------------------
// byte_stuffed_packet_deframer_tb
// Self-checking bench for the deframer. A driver pushes raw bytes from a
// queue, a monitor compares each delivered byte with a local deframing
// predictor, and code registers change between phases while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_stuffed_packet_deframer_tb;
    import bspd_pkg::*;

    localparam int PKT_DEPTH     = DEFAULT_MAX_PACKET_BYTES;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;

    // one delivered byte
    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [LENGTH_W-1:0] length;
    } deframed_t;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [BYTE_W-1:0]    cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    in_byte    = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 out_last;
    logic [LENGTH_W-1:0]  out_length;

    // stimulus and expectation stores
    logic [BYTE_W-1:0] raw_stream[$];
    deframed_t         deframed_q[$];
    int unsigned       bytes_queued  = 0;
    int unsigned       bytes_taken   = 0;
    int unsigned       mismatches    = 0;
    int unsigned       quiet_cycles  = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    logic [BYTE_W-1:0] launch_byte;

    // predictor copy of code registers and framing state
    logic [BYTE_W-1:0] start_code   = RST_START_CODE;
    logic [BYTE_W-1:0] end_code     = RST_END_CODE;
    logic [BYTE_W-1:0] escape_code  = RST_ESCAPE_CODE;
    logic [BYTE_W-1:0] unstuff_mask = RST_UNSTUFF_MASK;
    logic [BYTE_W-1:0] frame_buf[PKT_DEPTH];
    logic              frame_open   = 1'b0;
    int                frame_fill   = 0;
    logic              unstuff_armed = 1'b0;

    byte_stuffed_packet_deframer #(
        .MAX_PACKET_BYTES(PKT_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .out_length (out_length)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // deframe one raw byte, queue whatever it delivers
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        deframed_t         r;
        logic [BYTE_W-1:0] d;
        if (b == start_code)
        begin
            frame_fill = 0;
            frame_open = 1'b1;
        end
        else if (b == end_code)
        begin
            if (frame_open && frame_fill > 0)
            begin
                for (int k = 0; k < frame_fill; k++)
                begin
                    r.data   = frame_buf[k];
                    r.last   = (k + 1 == frame_fill);
                    r.length = LENGTH_W'(frame_fill);
                    deframed_q.push_back(r);
                end
            end
            frame_open = 1'b0;
        end
        else if (b == escape_code)
        begin
            unstuff_armed = 1'b1;
        end
        else if (frame_open)
        begin
            d = b;
            if (unstuff_armed)
            begin
                d = b & ~unstuff_mask;
                unstuff_armed = 1'b0;
            end
            if (frame_fill < PKT_DEPTH)
            begin
                frame_buf[frame_fill] = d;
                frame_fill++;
            end
            else
            begin
                frame_open = 1'b0;
            end
        end
    endtask

    // input driver: predict at launch, a presented transaction is held until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                bytes_taken++;
            end
            if (raw_stream.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                launch_byte = raw_stream.pop_front();
                deframe_byte(launch_byte);
                in_byte  <= launch_byte;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output monitor and random back-pressure
    always @(posedge clk)
    begin
        deframed_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (deframed_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h", out_byte));
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  out_byte, want.data));
                    end
                    if (out_last !== want.last)
                    begin
                        report_mismatch($sformatf("out_last %b, want %b",
                                                  out_last, want.last));
                    end
                    if (out_length !== want.length)
                    begin
                        report_mismatch($sformatf("out_length %0d, want %0d",
                                                  out_length, want.length));
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send(input logic [BYTE_W-1:0] b);
        raw_stream.push_back(b);
        bytes_queued++;
    endtask

    // random byte that is not one of the codes
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(255));
        while (b == start_code || b == end_code || b == escape_code)
        begin
            b = BYTE_W'($urandom_range(255));
        end
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_START_CODE:   start_code   = val;
            REG_END_CODE:     end_code     = val;
            REG_ESCAPE_CODE:  escape_code  = val;
            REG_UNSTUFF_MASK: unstuff_mask = val;
            default:          ;
        endcase
    endtask

    task automatic apply_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                               input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] m);
        write_reg(REG_START_CODE, s);
        write_reg(REG_END_CODE, e);
        write_reg(REG_ESCAPE_CODE, x);
        write_reg(REG_UNSTUFF_MASK, m);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every byte is taken and every delivery seen, then let the block settle
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || deframed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed packets with random content, plus broken frames and noise
    task automatic add_traffic(input int unsigned n_bytes);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send(start_code);
                len = ($urandom_range(15) == 0) ? $urandom_range(7, 12)
                                                : $urandom_range(1, 6);
                repeat (len)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        send(escape_code);
                    end
                    send(plain_byte());
                end
                send(end_code);
            end
            else if (pick < 85)
            begin
                send(start_code);
                repeat ($urandom_range(0, 4)) send(plain_byte());
                case ($urandom_range(2))
                    0:       send(start_code);
                    1:       send(escape_code);
                    default: send(end_code);
                endcase
            end
            else
            begin
                case ($urandom_range(2))
                    0:       send(BYTE_W'($urandom_range(255)));
                    1:       send(escape_code);
                    default: send(end_code);
                endcase
            end
        end
    endtask

    initial
    begin
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 18;
        recv_idle_pct = 48;

        // reset codes: corner cases of the framing rules
        send(end_code);            // end with no open packet
        send(8'h55);               // data outside a packet is dropped
        send(escape_code);         // escape outside a packet still arms
        send(start_code);
        send(escape_code);
        send(8'hFF);               // unstuffed
        send(8'h00);
        send(end_code);
        send(start_code);          // empty packet delivers nothing
        send(end_code);
        send(start_code);
        send(8'hAA);
        send(start_code);          // restart drops the packet in progress
        send(8'h01);
        send(8'h80);
        send(end_code);
        send(escape_code);         // flag survives a start code
        send(start_code);
        send(8'h7F);
        send(8'h20);
        send(end_code);
        add_traffic(5);
        wait_drained();

        // extreme codes, full store and overflow
        apply_codes(8'h00, 8'hFF, 8'h80, 8'hFF);
        send(start_code);
        for (i = 0; i < PKT_DEPTH; i++)
        begin
            send(plain_byte());
        end
        send(escape_code);
        send(plain_byte());        // one byte too many abandons the packet
        send(end_code);
        send(start_code);
        send(8'h7F);               // flag was consumed by the dropped byte
        send(end_code);
        wait_drained();

        // roles swapped
        send_idle_pct = 48;
        recv_idle_pct = 18;
        apply_codes(8'hFF, 8'h00, 8'h7E, 8'h00);
        add_traffic(5);
        wait_drained();

        // end and escape share a value: end wins
        apply_codes(8'h41, 8'h42, 8'h42, 8'h0F);
        add_traffic(4);
        wait_drained();

        // all codes equal: start wins, nothing is ever delivered
        apply_codes(8'hA5, 8'hA5, 8'hA5, 8'hA5);
        add_traffic(3);
        wait_drained();

        // no idling, random codes
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_codes(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                    BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        add_traffic(5);
        wait_drained();

        if (deframed_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d bytes never delivered", deframed_q.size()));
        end
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bspd_pkg.sv
rtl/core/bspd_datapath.sv
rtl/core/bspd_ctrl.sv
rtl/core/byte_stuffed_packet_deframer.sv
test/byte_stuffed_packet_deframer_tb.sv
